/* sv/apt_pkg.sv */
`timescale 1ns / 1ps

package apt_pkg;

  // Fixed-point format and matrix geometry
  localparam int unsigned DataW      = 32;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned NumRows    = 4;
  localparam int unsigned NumCols    = 3;
  localparam int unsigned NumEntries = NumRows * NumCols;
  localparam int unsigned NumTerms   = 3;
  localparam int unsigned IdxW       = 4;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic [IdxW-1:0]         idx_t;

  // Command codes
  localparam logic CmdWrite     = 1'b0;
  localparam logic CmdTransform = 1'b1;

  // Fixed-point one
  localparam data_t FixOne = data_t'(64'sd1 <<< FracBits);

  // Identity value of one matrix entry
  function automatic data_t mat_reset_val(input int unsigned idx);
    data_t val;
    val = '0;
    if ((idx % NumCols) == (idx / NumCols) && (idx / NumCols) < NumTerms) begin
      val = FixOne;
    end
    return val;
  endfunction

endpackage

/* sv/apt_in_if.sv */
`timescale 1ns / 1ps

interface apt_in_if;
  logic              valid;
  logic              ready;
  logic              cmd;
  apt_pkg::idx_t     entry_index;
  apt_pkg::data_t    entry_value;
  apt_pkg::data_t    vec_x;
  apt_pkg::data_t    vec_y;
  apt_pkg::data_t    vec_z;

  modport source (output valid, cmd, entry_index, entry_value, vec_x, vec_y, vec_z,
                  input ready);
  modport sink   (input valid, cmd, entry_index, entry_value, vec_x, vec_y, vec_z,
                  output ready);
endinterface

/* sv/apt_out_if.sv */
`timescale 1ns / 1ps

interface apt_out_if;
  logic           valid;
  logic           ready;
  apt_pkg::data_t out_x;
  apt_pkg::data_t out_y;
  apt_pkg::data_t out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

/* sv/apt_lane.sv */
`timescale 1ns / 1ps

// One output component: three fixed-point products and the translation term
module apt_lane (
  input  logic           clk_i,
  input  logic           en_i,
  input  apt_pkg::data_t coef_i [apt_pkg::NumTerms],
  input  apt_pkg::data_t trans_i,
  input  apt_pkg::data_t pt_i   [apt_pkg::NumTerms],
  output apt_pkg::data_t sum_o
);

  logic signed [2*apt_pkg::DataW-1:0] full_prod [apt_pkg::NumTerms];
  logic signed [2*apt_pkg::DataW-1:0] shf_prod  [apt_pkg::NumTerms];
  apt_pkg::data_t                     prod_d    [apt_pkg::NumTerms];
  apt_pkg::data_t                     prod_q    [apt_pkg::NumTerms];
  apt_pkg::data_t                     trans_q;

  // Multiply, shift out the fraction bits, keep the low word
  always_comb begin
    for (int t = 0; t < int'(apt_pkg::NumTerms); t++) begin
      full_prod[t] = (2*apt_pkg::DataW)'(coef_i[t]) * (2*apt_pkg::DataW)'(pt_i[t]);
      shf_prod[t]  = full_prod[t] >>> apt_pkg::FracBits;
      prod_d[t]    = shf_prod[t][apt_pkg::DataW-1:0];
    end
  end

  // Hold products and translation with the request
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      trans_q <= trans_i;
    end
  end

  // Sum with wrap-around
  assign sum_o = prod_q[0] + prod_q[1] + prod_q[2] + trans_q;

endmodule

/* sv/affine_point_transform_4x3_top.sv */
`timescale 1ns / 1ps

// Fixed-point 4x3 affine point transform.
// req_i carries one request per valid/ready handshake. cmd selects a matrix
// write (entry_index, entry_value; no response, indexes above eleven are
// dropped) or a point transform (vec_x, vec_y, vec_z). Each transform gives
// one response on rsp_o: out_x, out_y, out_z, each the sum of three
// products (matrix entry times point component, shifted right by the
// fraction bits) plus the row-3 translation, wrapped to 32 bits.
// A transform accepted at a clock edge loads the product register at
// that same edge, then moves to the output register, which drives
// rsp_o.valid, at an edge where the output register can advance.
// Throughput: one request per cycle while the output keeps draining, set by
// the three lanes of three multipliers each.
// A write takes effect for every transform accepted after it; transforms
// already accepted keep the matrix they saw.
// Reset loads the identity matrix with zero translation and empties the
// pipeline. When rsp_o.ready is low the output holds, the product stage
// fills, and then req_i.ready drops until the output drains.
module affine_point_transform_4x3_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  apt_in_if.sink    req_i,
  apt_out_if.source rsp_o
);

  apt_pkg::data_t mat_q [apt_pkg::NumEntries];
  logic           v1_q;
  logic           out_valid_q;
  apt_pkg::data_t out_x_q, out_y_q, out_z_q;
  logic           out_adv;
  logic           s1_adv;
  logic           in_acc;
  logic           wr_en;
  apt_pkg::data_t pt     [apt_pkg::NumTerms];
  apt_pkg::data_t coef   [apt_pkg::NumCols][apt_pkg::NumTerms];
  apt_pkg::data_t lane_sum [apt_pkg::NumCols];

  // Pipeline flow control
  assign out_adv     = !out_valid_q || rsp_o.ready;
  assign s1_adv      = !v1_q || out_adv;
  assign req_i.ready = s1_adv;
  assign in_acc      = req_i.valid && req_i.ready;
  assign wr_en       = in_acc && (req_i.cmd == apt_pkg::CmdWrite) &&
                       (req_i.entry_index < apt_pkg::IdxW'(apt_pkg::NumEntries));

  // Matrix entries, identity after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(apt_pkg::NumEntries); i++) begin
        mat_q[i] <= apt_pkg::mat_reset_val(i);
      end
    end else if (wr_en) begin
      mat_q[req_i.entry_index] <= req_i.entry_value;
    end
  end

  // Route point and matrix columns to the lanes
  assign pt[0] = req_i.vec_x;
  assign pt[1] = req_i.vec_y;
  assign pt[2] = req_i.vec_z;

  always_comb begin
    for (int c = 0; c < int'(apt_pkg::NumCols); c++) begin
      for (int t = 0; t < int'(apt_pkg::NumTerms); t++) begin
        coef[c][t] = mat_q[t*apt_pkg::NumCols + c];
      end
    end
  end

  for (genvar c = 0; c < apt_pkg::NumCols; c++) begin : g_lane
    apt_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (s1_adv),
      .coef_i  (coef[c]),
      .trans_i (mat_q[apt_pkg::NumTerms*apt_pkg::NumCols + c]),
      .pt_i    (pt),
      .sum_o   (lane_sum[c])
    );
  end

  // Track valid transforms through the product stage and output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        v1_q <= in_acc && (req_i.cmd == apt_pkg::CmdTransform);
      end
      if (out_adv) begin
        out_valid_q <= v1_q;
      end
    end
  end

  // Merge lane sums into the output register
  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      out_x_q <= lane_sum[0];
      out_y_q <= lane_sum[1];
      out_z_q <= lane_sum[2];
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.out_x = out_x_q;
  assign rsp_o.out_y = out_y_q;
  assign rsp_o.out_z = out_z_q;

`ifndef SYNTHESIS
  a_xform_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && req_i.cmd == apt_pkg::CmdTransform) |=> v1_q)
    else $error("accepted transform did not enter product stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !s1_adv) |=> v1_q)
    else $error("stalled transform dropped from product stage");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (v1_q && out_valid_q && !rsp_o.ready))
    else $error("request blocked while pipeline has room");

  a_write_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (mat_q[$past(req_i.entry_index)] == $past(req_i.entry_value)))
    else $error("matrix write lost");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && out_adv) |=> out_valid_q)
    else $error("product stage result not moved to output");
`endif

endmodule

/* tb/sv/tb_affine_point_transform_4x3_top.sv */
`timescale 1ns / 1ps

module tb_affine_point_transform_4x3_top;
  import apt_pkg::*;

  localparam int unsigned ResetCycles   = 7;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomItems   = 1830;
  localparam int unsigned MaxReported   = 10;

  localparam data_t MaxVal = 32'sh7fff_ffff;
  localparam data_t MinVal = 32'sh8000_0000;
  localparam data_t NegOne = -32'sd1;

  // Entry indexes past the matrix, dropped by the block
  localparam idx_t FirstBadIdx = idx_t'(NumEntries);
  localparam idx_t LastBadIdx  = '1;

  typedef enum int unsigned {
    StallNone,
    StallCoin,
    StallHeavy,
    StallLong
  } stall_mode_e;

  typedef struct {
    data_t out_x;
    data_t out_y;
    data_t out_z;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  apt_in_if  req_if ();
  apt_out_if rsp_if ();

  affine_point_transform_4x3_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the matrix and the points still owed by the block
  data_t       shadow_matrix [NumEntries];
  point_t      expected_points [$];
  int unsigned fail_count = 0;
  int unsigned burst_left = 0;

  // Fixed-point product: full product, arithmetic shift, low word
  function automatic data_t fix_mul(input data_t a, input data_t b);
    logic signed [63:0] prod;
    prod = longint'(a) * longint'(b);
    prod = prod >>> FracBits;
    return prod[DataW-1:0];
  endfunction

  function automatic data_t edge_value(input int unsigned k);
    case (k % 6)
      0:       return MaxVal;
      1:       return MinVal;
      2:       return NegOne;
      3:       return '0;
      4:       return FixOne;
      default: return -FixOne;
    endcase
  endfunction

  // Mix of edge values, raw words and values within +/-8.0
  function automatic data_t pick_fixed();
    case ($urandom_range(7, 0))
      0:       return edge_value($urandom_range(5, 0));
      1, 2:    return data_t'($urandom());
      default: return data_t'($urandom_range(32'h0010_0000, 0)) - 32'sh0008_0000;
    endcase
  endfunction

  task automatic flag_failure(input string msg);
    fail_count++;
    if (fail_count <= MaxReported) begin
      $display("%s", msg);
    end
  endtask

  // Drive one request, wait for its handshake, then update the prediction
  task automatic issue_request(input logic cmd, input idx_t idx, input data_t value,
                               input data_t x, input data_t y, input data_t z);
    int unsigned gap;
    data_t       comps [NumCols];
    point_t      next_point;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 50)
                                               : $urandom_range(24, 1);
    end
    burst_left--;
    req_if.valid       <= 1'b1;
    req_if.cmd         <= cmd;
    req_if.entry_index <= idx;
    req_if.entry_value <= value;
    req_if.vec_x       <= x;
    req_if.vec_y       <= y;
    req_if.vec_z       <= z;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);

    if (cmd == CmdWrite) begin
      if (idx < NumEntries) begin
        shadow_matrix[idx] = value;
      end
    end else begin
      for (int c = 0; c < NumCols; c++) begin
        comps[c] = fix_mul(shadow_matrix[c], x)
                 + fix_mul(shadow_matrix[NumCols + c], y)
                 + fix_mul(shadow_matrix[2 * NumCols + c], z)
                 + shadow_matrix[3 * NumCols + c];
      end
      next_point.out_x = comps[0];
      next_point.out_y = comps[1];
      next_point.out_z = comps[2];
      expected_points.push_back(next_point);
    end
  endtask

  task automatic write_entry(input idx_t idx, input data_t value);
    issue_request(CmdWrite, idx, value, data_t'($urandom()), data_t'($urandom()),
                  data_t'($urandom()));
  endtask

  task automatic transform_point(input data_t x, input data_t y, input data_t z);
    issue_request(CmdTransform, idx_t'($urandom()), data_t'($urandom()), x, y, z);
  endtask

  // Identity matrix after reset passes points through unchanged
  task automatic test_identity_points();
    transform_point('0, '0, '0);
    transform_point(MaxVal, MinVal, NegOne);
    transform_point(FixOne, -FixOne, data_t'($urandom()));
  endtask

  // Load every entry with an edge value, then push extreme points through
  task automatic test_entry_writes();
    for (int unsigned e = 0; e < NumEntries; e++) begin
      write_entry(idx_t'(e), edge_value(e));
    end
    transform_point(MaxVal, MinVal, MaxVal);
    transform_point(MinVal, NegOne, FixOne);
  endtask

  // Writes past the last entry must leave the matrix alone
  task automatic test_ignored_indexes();
    write_entry(FirstBadIdx, MaxVal);
    write_entry(LastBadIdx, MinVal);
    transform_point(MaxVal, MaxVal, MinVal);
  endtask

  // Random stream: matrix reloads, single writes, dropped writes, transforms
  task automatic test_random_stream();
    int unsigned counted;
    int unsigned pick;
    counted = 0;
    while (counted < RandomItems) begin
      pick = $urandom_range(99, 0);
      if (pick < 4) begin
        for (int unsigned e = 0; e < NumEntries; e++) begin
          write_entry(idx_t'(e), pick_fixed());
        end
        counted += NumEntries;
      end else if (pick < 28) begin
        write_entry(idx_t'($urandom_range(NumEntries - 1, 0)), pick_fixed());
        counted++;
      end else if (pick < 32) begin
        write_entry(idx_t'($urandom_range(LastBadIdx, FirstBadIdx)), data_t'($urandom()));
        counted++;
      end else begin
        transform_point(pick_fixed(), pick_fixed(), pick_fixed());
        counted++;
      end
    end
  endtask

  // Stimulus and end of run
  initial begin
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.cmd         = CmdWrite;
    req_if.entry_index = '0;
    req_if.entry_value = '0;
    req_if.vec_x       = '0;
    req_if.vec_y       = '0;
    req_if.vec_z       = '0;
    for (int unsigned e = 0; e < NumEntries; e++) begin
      shadow_matrix[e] = ((e % NumCols) == (e / NumCols)) ? FixOne : '0;
    end
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_identity_points();
    test_entry_writes();
    test_ignored_indexes();
    test_random_stream();

    req_if.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Response ready: switch between stall styles in stretches
  initial begin
    int unsigned stretch;
    int unsigned stall_left;
    stall_mode_e mode;
    rsp_if.ready = 1'b0;
    stretch      = 0;
    stall_left   = 0;
    mode         = StallNone;
    forever begin
      @(posedge clk_i);
      if (stretch == 0) begin
        mode    = stall_mode_e'($urandom_range(3, 0));
        stretch = $urandom_range(300, 20);
      end
      stretch--;
      case (mode)
        StallNone:  rsp_if.ready <= 1'b1;
        StallCoin:  rsp_if.ready <= 1'($urandom_range(1, 0));
        StallHeavy: rsp_if.ready <= ($urandom_range(3, 0) == 0);
        default: begin
          if (stall_left == 0) begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(7, 0) == 0) begin
              stall_left = $urandom_range(12, 1);
            end
          end else begin
            rsp_if.ready <= 1'b0;
            stall_left--;
          end
        end
      endcase
    end
  end

  // Compare each accepted response with the oldest predicted point
  always @(posedge clk_i) begin : check_responses
    point_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_points.size() == 0) begin
        flag_failure($sformatf("unexpected response x=%h y=%h z=%h",
                               rsp_if.out_x, rsp_if.out_y, rsp_if.out_z));
      end else begin
        want = expected_points.pop_front();
        if (rsp_if.out_x !== want.out_x) begin
          flag_failure($sformatf("out_x mismatch: expected %h got %h",
                                 want.out_x, rsp_if.out_x));
        end
        if (rsp_if.out_y !== want.out_y) begin
          flag_failure($sformatf("out_y mismatch: expected %h got %h",
                                 want.out_y, rsp_if.out_y));
        end
        if (rsp_if.out_z !== want.out_z) begin
          flag_failure($sformatf("out_z mismatch: expected %h got %h",
                                 want.out_z, rsp_if.out_z));
        end
      end
    end
  end

  // Abort when no handshake happens on either side for too long
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule
